// ===== src/qte_pkg.sv =====
// shared types, constants and the arctangent step table for the quaternion to euler block
package qte_pkg;

   localparam int CORDIC_STEPS = 20;
   localparam int SQRT_STAGES = 31;
   localparam int CW = 38;   // width of atan2 operands
   localparam int XW = 40;   // width of cordic x/y datapath
   localparam int ZW = 35;   // width of cordic angle, q.30 radians
   localparam int RW = 31;   // width of square root result
   localparam int NW = 62;   // width of square root radicand
   localparam int PIPE_DEPTH = 4 + SQRT_STAGES + 1 + CORDIC_STEPS;

   localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;
   localparam logic signed [CW-1:0] ONE_Q30 = 38'sd1073741824;
   localparam logic signed [13:0] CDEG_PER_RAD = 14'sd5730;

   typedef struct packed {
      logic signed [31:0] quat_w;
      logic signed [31:0] quat_x;
      logic signed [31:0] quat_y;
      logic signed [31:0] quat_z;
   } req_type;

   typedef struct packed {
      logic signed [14:0] roll_cdeg;
      logic signed [15:0] pitch_cdeg;
      logic signed [15:0] yaw_cdeg;
      logic asin_clamped;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] s;
      logic signed [CW-1:0] pn;
      logic signed [CW-1:0] pd;
      logic signed [CW-1:0] yn;
      logic signed [CW-1:0] yd;
      logic clamped;
   } side_type;

   // floor(atan(2^-i) * 2^30)
   function automatic logic [29:0] atan_step(input logic [4:0] idx);
      logic [29:0] r;
      unique case (idx)
         5'd0: r = 30'd843314856;
         5'd1: r = 30'd497837829;
         5'd2: r = 30'd263043836;
         5'd3: r = 30'd133525158;
         5'd4: r = 30'd67021686;
         5'd5: r = 30'd33543515;
         5'd6: r = 30'd16775850;
         5'd7: r = 30'd8388437;
         5'd8: r = 30'd4194282;
         5'd9: r = 30'd2097149;
         5'd10: r = 30'd1048575;
         5'd11: r = 30'd524287;
         5'd12: r = 30'd262143;
         5'd13: r = 30'd131071;
         5'd14: r = 30'd65535;
         5'd15: r = 30'd32767;
         5'd16: r = 30'd16383;
         5'd17: r = 30'd8191;
         5'd18: r = 30'd4095;
         5'd19: r = 30'd2047;
         5'd20: r = 30'd1023;
         5'd21: r = 30'd511;
         5'd22: r = 30'd255;
         5'd23: r = 30'd127;
         5'd24: r = 30'd63;
         5'd25: r = 30'd31;
         5'd26: r = 30'd15;
         5'd27: r = 30'd7;
         5'd28: r = 30'd3;
         5'd29: r = 30'd1;
         default: r = 30'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== src/qte_sqrt.sv =====
// pipelined floor integer square root, one result bit per stage
module qte_sqrt (
   input  logic clock,
   input  logic en,
   input  logic [qte_pkg::NW-1:0] radicand,
   output logic [qte_pkg::RW-1:0] root
);

   localparam int N = qte_pkg::SQRT_STAGES;

   logic [32:0] rem_ff [N];
   logic [qte_pkg::RW-1:0] root_ff [N];
   logic [qte_pkg::NW-1:0] rad_ff [N];

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [32:0] rem_prev;
      logic [qte_pkg::RW-1:0] root_prev;
      logic [qte_pkg::NW-1:0] rad_prev;
      logic [34:0] rem_sh;
      logic [34:0] trial;
      logic [32:0] rem_in;
      logic [qte_pkg::RW-1:0] root_in;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign root_prev = '0;
         assign rad_prev = radicand;
      end else begin : g_rest
         assign rem_prev = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
         assign rad_prev = rad_ff[k-1];
      end

      always_comb begin
         rem_sh = {rem_prev, rad_prev[qte_pkg::NW-1 -: 2]};
         trial = {2'b00, root_prev, 2'b01};
         if (rem_sh >= trial) begin
            rem_in = 33'(rem_sh - trial);
            root_in = {root_prev[qte_pkg::RW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[32:0];
            root_in = {root_prev[qte_pkg::RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k] <= {rad_prev[qte_pkg::NW-3:0], 2'b00};
         end
      end
   end

   assign root = root_ff[N-1];

endmodule

// ===== src/qte_cordic.sv =====
// pipelined vectoring cordic arctangent, one rotation per stage
module qte_cordic (
   input  logic clock,
   input  logic en,
   input  logic signed [qte_pkg::CW-1:0] num,
   input  logic signed [qte_pkg::CW-1:0] den,
   output logic signed [qte_pkg::ZW-1:0] angle
);

   localparam int N = qte_pkg::CORDIC_STEPS;

   logic signed [qte_pkg::XW-1:0] x_ff [N+1];
   logic signed [qte_pkg::XW-1:0] y_ff [N+1];
   logic signed [qte_pkg::ZW-1:0] z_ff [N+1];
   logic zero_ff [N+1];

   logic signed [qte_pkg::XW-1:0] x0_in, y0_in;
   logic signed [qte_pkg::ZW-1:0] z0_in;
   logic zero0_in;

   // quadrant fold and the exact-zero cases
   always_comb begin
      x0_in = qte_pkg::XW'(den);
      y0_in = qte_pkg::XW'(num);
      z0_in = '0;
      zero0_in = (num == 0) && (den >= 0);
      if (den < 0) begin
         x0_in = -qte_pkg::XW'(den);
         y0_in = -qte_pkg::XW'(num);
         z0_in = (num >= 0) ? qte_pkg::PI_Q30 : -qte_pkg::PI_Q30;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= x0_in;
         y_ff[0] <= y0_in;
         z_ff[0] <= z0_in;
         zero_ff[0] <= zero0_in;
      end
   end

   for (genvar i = 0; i < N; i++) begin : g_rot
      logic signed [qte_pkg::XW-1:0] xs, ys;
      logic signed [qte_pkg::ZW-1:0] step;

      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;
      assign step = qte_pkg::ZW'(qte_pkg::atan_step(5'(i)));

      always_ff @(posedge clock) begin
         if (en) begin
            if (y_ff[i] > 0) begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
               z_ff[i+1] <= z_ff[i] + step;
            end else begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
               z_ff[i+1] <= z_ff[i] - step;
            end
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   assign angle = zero_ff[N] ? '0 : z_ff[N];

endmodule

// ===== src/quaternion_to_euler_angles.sv =====
// top level: quaternion (q2.30) to roll, pitch and yaw in hundredths of a degree
// Takes one transaction per cycle while the output is not stalled. Each result passes
// through four product and sum stages, a 31-stage square root for the roll cosine, then
// 1 + CORDIC_STEPS cordic stages for all three angles in parallel and one scaling stage.
// The whole pipeline halts as one while a result is stalled at the output; the block
// holds no state between transactions.
module quaternion_to_euler_angles (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  qte_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output qte_pkg::rsp_type rsp_data
);

   localparam int D = qte_pkg::SQRT_STAGES + 2;
   localparam int CL = qte_pkg::CORDIC_STEPS + 1;
   localparam int PD = qte_pkg::PIPE_DEPTH;

   logic en;
   logic valid_ff [PD];
   logic rsp_valid_ff;
   qte_pkg::rsp_type rsp_data_ff;

   assign en = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !en;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PD; i++) valid_ff[i] <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff[0] <= req_valid;
         for (int i = 1; i < PD; i++) valid_ff[i] <= valid_ff[i-1];
         rsp_valid_ff <= valid_ff[PD-1];
      end
   end

   // stage 1: component products at q.30, floor
   logic signed [33:0] wy_ff, xz_ff, yz_ff, wx_ff, xx_ff, yy_ff, xy_ff, wz_ff, ww_ff, zz_ff;

   function automatic logic signed [33:0] mulq(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p[63:30];
   endfunction

   always_ff @(posedge clock) begin
      if (en) begin
         wy_ff <= mulq(req_data.quat_w, req_data.quat_y);
         xz_ff <= mulq(req_data.quat_x, req_data.quat_z);
         yz_ff <= mulq(req_data.quat_y, req_data.quat_z);
         wx_ff <= mulq(req_data.quat_w, req_data.quat_x);
         xx_ff <= mulq(req_data.quat_x, req_data.quat_x);
         yy_ff <= mulq(req_data.quat_y, req_data.quat_y);
         xy_ff <= mulq(req_data.quat_x, req_data.quat_y);
         wz_ff <= mulq(req_data.quat_w, req_data.quat_z);
         ww_ff <= mulq(req_data.quat_w, req_data.quat_w);
         zz_ff <= mulq(req_data.quat_z, req_data.quat_z);
      end
   end

   // stage 2: sums and asin argument saturation
   qte_pkg::side_type side_in;
   qte_pkg::side_type side_ff;
   logic signed [qte_pkg::CW-1:0] s_full;

   always_comb begin
      s_full = (qte_pkg::CW'(wy_ff) - qte_pkg::CW'(xz_ff)) <<< 1;
      side_in.clamped = 1'b0;
      side_in.s = 32'(s_full);
      if (s_full > qte_pkg::ONE_Q30) begin
         side_in.s = 32'(qte_pkg::ONE_Q30);
         side_in.clamped = 1'b1;
      end else if (s_full < -qte_pkg::ONE_Q30) begin
         side_in.s = 32'(-qte_pkg::ONE_Q30);
         side_in.clamped = 1'b1;
      end
      side_in.pn = (qte_pkg::CW'(yz_ff) + qte_pkg::CW'(wx_ff)) <<< 1;
      side_in.pd = qte_pkg::ONE_Q30 - ((qte_pkg::CW'(xx_ff) + qte_pkg::CW'(yy_ff)) <<< 1);
      side_in.yn = (qte_pkg::CW'(xy_ff) + qte_pkg::CW'(wz_ff)) <<< 1;
      side_in.yd = qte_pkg::CW'(ww_ff) + qte_pkg::CW'(xx_ff)
                   - qte_pkg::CW'(yy_ff) - qte_pkg::CW'(zz_ff);
   end

   always_ff @(posedge clock) begin
      if (en) side_ff <= side_in;
   end

   // operands wait here while the square root runs
   qte_pkg::side_type side_dly_ff [D];

   always_ff @(posedge clock) begin
      if (en) begin
         side_dly_ff[0] <= side_ff;
         for (int i = 1; i < D; i++) side_dly_ff[i] <= side_dly_ff[i-1];
      end
   end

   // stages 3 and 4: radicand 2^60 - s^2
   logic [60:0] sq_ff;
   logic [qte_pkg::NW-1:0] rad_ff;
   logic signed [63:0] sq_full;

   assign sq_full = side_ff.s * side_ff.s;

   always_ff @(posedge clock) begin
      if (en) begin
         sq_ff <= sq_full[60:0];
         rad_ff <= (qte_pkg::NW'(1) << 60) - qte_pkg::NW'(sq_ff);
      end
   end

   logic [qte_pkg::RW-1:0] root;

   qte_sqrt u_sqrt (
      .clock(clock),
      .en(en),
      .radicand(rad_ff),
      .root(root)
   );

   qte_pkg::side_type side_al;
   assign side_al = side_dly_ff[D-1];

   logic signed [qte_pkg::ZW-1:0] roll_ang, pitch_ang, yaw_ang;

   qte_cordic u_roll (
      .clock(clock),
      .en(en),
      .num(qte_pkg::CW'(side_al.s)),
      .den(qte_pkg::CW'($signed({1'b0, root}))),
      .angle(roll_ang)
   );

   qte_cordic u_pitch (
      .clock(clock),
      .en(en),
      .num(side_al.pn),
      .den(side_al.pd),
      .angle(pitch_ang)
   );

   qte_cordic u_yaw (
      .clock(clock),
      .en(en),
      .num(side_al.yn),
      .den(side_al.yd),
      .angle(yaw_ang)
   );

   logic clamp_dly_ff [CL];

   always_ff @(posedge clock) begin
      if (en) begin
         clamp_dly_ff[0] <= side_al.clamped;
         for (int i = 1; i < CL; i++) clamp_dly_ff[i] <= clamp_dly_ff[i-1];
      end
   end

   // radians q.30 to hundredths of a degree, round half up
   function automatic logic signed [18:0] to_cdeg(input logic signed [qte_pkg::ZW-1:0] a);
      logic signed [48:0] p;
      p = 49'(a) * 49'(qte_pkg::CDEG_PER_RAD) + (49'sd1 <<< 29);
      return p[48:30];
   endfunction

   qte_pkg::rsp_type rsp_in;
   logic signed [18:0] roll_c, pitch_c, yaw_c;

   always_comb begin
      roll_c = to_cdeg(roll_ang);
      pitch_c = to_cdeg(pitch_ang);
      yaw_c = to_cdeg(yaw_ang);
      rsp_in.roll_cdeg = roll_c[14:0];
      rsp_in.pitch_cdeg = pitch_c[15:0];
      rsp_in.yaw_cdeg = yaw_c[15:0];
      rsp_in.asin_clamped = clamp_dly_ff[CL-1];
   end

   always_ff @(posedge clock) begin
      if (en) rsp_data_ff <= rsp_in;
   end

`ifndef SYNTH
   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> valid_ff[0])
      else $error("accepted transaction did not enter the pipeline");

   a_hold_stalls_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("input taken while output stalled");

   a_result_from_pipe: assert property (@(posedge clock) disable iff (reset)
      en && !valid_ff[PD-1] |=> !rsp_valid_ff)
      else $error("result issued without a transaction in flight");
`endif

endmodule
